@@ rtl/core/mets_pkg.sv @@
// Shared types, constants and helpers for the Mandelbrot escape-time pixel engine.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package mets_pkg;

    localparam int Q_W         = 32;    // signed fixed-point word
    localparam int FRAC_BITS   = 28;    // fraction bits of the fixed-point word
    localparam int PROD_W      = 2 * Q_W;
    localparam int STEP_W      = Q_W + 1;
    localparam int COORD_W     = 12;
    localparam int DIM_CFG_W   = 13;
    localparam int LIMIT_W     = 16;
    localparam int INDEX_W     = 24;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_DIM_DEFAULT = 4096;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_LEFT_RE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_TOP_IM     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_RIGHT_RE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_BOTTOM_IM  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd6;

    // reset values: view -2.0..1.0 by -1.0..1.0, 1024 x 768, 256 updates
    localparam logic signed [Q_W-1:0] RST_VIEW_LEFT_RE   = 32'shE000_0000;
    localparam logic signed [Q_W-1:0] RST_VIEW_TOP_IM    = 32'shF000_0000;
    localparam logic signed [Q_W-1:0] RST_VIEW_RIGHT_RE  = 32'sh1000_0000;
    localparam logic signed [Q_W-1:0] RST_VIEW_BOTTOM_IM = 32'sh1000_0000;
    localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_WIDTH    = 13'd1024;
    localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_HEIGHT   = 13'd768;
    localparam logic [LIMIT_W-1:0]    RST_ITER_LIMIT     = 16'd256;

    localparam logic signed [PROD_W-1:0] Q_MAX_WIDE = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] Q_MIN_WIDE = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [PROD_W-1:0] FOUR_Q     = 64'sh4 << FRAC_BITS;

    typedef struct packed {
        logic signed [Q_W-1:0] left_re;
        logic signed [Q_W-1:0] top_im;
        logic signed [Q_W-1:0] right_re;
        logic signed [Q_W-1:0] bottom_im;
        logic [DIM_CFG_W-1:0]  width;
        logic [DIM_CFG_W-1:0]  height;
    } view_t;

    typedef struct packed {
        logic signed [Q_W-1:0] c_re;
        logic signed [Q_W-1:0] c_im;
        logic [INDEX_W-1:0]    index;
    } point_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_DONE
    } back_state_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        if (v > Q_MAX_WIDE)
            return Q_MAX_WIDE[Q_W-1:0];
        if (v < Q_MIN_WIDE)
            return Q_MIN_WIDE[Q_W-1:0];
        return v[Q_W-1:0];
    endfunction

endpackage

@@ rtl/core/mets_divider.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on mets_pkg for the word width.
module mets_divider #(
    parameter int DIVISOR_W = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mets_pkg::Q_W-1:0]        dividend,
    input  logic [DIVISOR_W-1:0]            divisor,
    input  logic                            negate,
    output logic                            done,
    output logic signed [mets_pkg::STEP_W-1:0] quotient
);

    localparam int CNT_W = $clog2(mets_pkg::Q_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [DIVISOR_W-1:0]       rem_reg;
    logic [DIVISOR_W-1:0]       rem_next;
    logic [mets_pkg::Q_W-1:0]   quo_reg;
    logic [DIVISOR_W-1:0]       divisor_reg;
    logic                       negate_reg;
    logic [DIVISOR_W:0]         trial;
    logic [DIVISOR_W:0]         trial_diff;
    logic                       q_bit;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[mets_pkg::Q_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        q_bit      = (trial >= {1'b0, divisor_reg});
        rem_next   = q_bit ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(mets_pkg::Q_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
            negate_reg  <= negate;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[mets_pkg::Q_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = negate_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

@@ rtl/core/mets_front.sv @@
// Front end: takes a pixel request, divides the view span into steps and maps
// the pixel to its point c and linear index. Uses mets_pkg and mets_divider.
module mets_front #(
    parameter int MAX_DIM = mets_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [mets_pkg::COORD_W-1:0]      pixel_col,
    input  logic [mets_pkg::COORD_W-1:0]      pixel_row,
    input  mets_pkg::view_t                   view,
    input  logic                              queue_full,
    output logic                              push,
    output mets_pkg::point_t                  point
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IPROD_W = mets_pkg::COORD_W + DIM_W;
    localparam int ISUM_W = (IPROD_W + 1 > mets_pkg::INDEX_W) ? IPROD_W + 1
                                                              : mets_pkg::INDEX_W;
    localparam int CPROD_W = mets_pkg::COORD_W + 1 + mets_pkg::STEP_W;

    mets_pkg::front_state_t state_reg;
    mets_pkg::front_state_t state_next;

    logic [mets_pkg::COORD_W-1:0]        col_reg;
    logic [mets_pkg::COORD_W-1:0]        row_reg;
    logic [DIM_W-1:0]                    eff_w;
    logic [DIM_W-1:0]                    eff_h;
    logic signed [mets_pkg::Q_W:0]       diff_re;
    logic signed [mets_pkg::Q_W:0]       diff_im;
    logic [mets_pkg::Q_W:0]              neg_re;
    logic [mets_pkg::Q_W:0]              neg_im;
    logic [mets_pkg::Q_W-1:0]            mag_re;
    logic [mets_pkg::Q_W-1:0]            mag_im;
    logic                                accept;
    logic                                done_re;
    logic                                done_im;
    logic signed [mets_pkg::STEP_W-1:0]  step_re;
    logic signed [mets_pkg::STEP_W-1:0]  step_im;
    logic signed [CPROD_W-1:0]           prod_re_reg;
    logic signed [CPROD_W-1:0]           prod_im_reg;
    logic [IPROD_W-1:0]                  idx_prod_reg;
    logic [ISUM_W-1:0]                   idx_sum;

    // zero counts as one, anything above MAX_DIM clamps to it
    always_comb
    begin
        if (view.width == '0)
            eff_w = DIM_W'(1);
        else if (32'(view.width) > 32'(MAX_DIM))
            eff_w = DIM_W'(MAX_DIM);
        else
            eff_w = DIM_W'(view.width);

        if (view.height == '0)
            eff_h = DIM_W'(1);
        else if (32'(view.height) > 32'(MAX_DIM))
            eff_h = DIM_W'(MAX_DIM);
        else
            eff_h = DIM_W'(view.height);
    end

    // span magnitude fits 32 bits: at most 2^32 - 1
    always_comb
    begin
        diff_re = (mets_pkg::Q_W + 1)'(view.right_re) - (mets_pkg::Q_W + 1)'(view.left_re);
        diff_im = (mets_pkg::Q_W + 1)'(view.bottom_im) - (mets_pkg::Q_W + 1)'(view.top_im);
        neg_re  = -diff_re;
        neg_im  = -diff_im;
        mag_re  = diff_re[mets_pkg::Q_W] ? neg_re[mets_pkg::Q_W-1:0] : diff_re[mets_pkg::Q_W-1:0];
        mag_im  = diff_im[mets_pkg::Q_W] ? neg_im[mets_pkg::Q_W-1:0] : diff_im[mets_pkg::Q_W-1:0];
    end

    assign accept = pixel_valid && !pixel_stall;

    mets_divider #(
        .DIVISOR_W(DIM_W)
    ) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (mag_re),
        .divisor  (eff_w),
        .negate   (diff_re[mets_pkg::Q_W]),
        .done     (done_re),
        .quotient (step_re)
    );

    mets_divider #(
        .DIVISOR_W(DIM_W)
    ) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (mag_im),
        .divisor  (eff_h),
        .negate   (diff_im[mets_pkg::Q_W]),
        .done     (done_im),
        .quotient (step_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mets_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        pixel_stall = 1'b1;
        push        = 1'b0;
        unique case (state_reg)
            mets_pkg::F_IDLE:
            begin
                pixel_stall = 1'b0;
                if (pixel_valid)
                    state_next = mets_pkg::F_DIV;
            end
            mets_pkg::F_DIV:
            begin
                // both dividers run in lockstep
                if (done_re && done_im)
                    state_next = mets_pkg::F_MUL;
            end
            mets_pkg::F_MUL:
            begin
                state_next = mets_pkg::F_PUSH;
            end
            mets_pkg::F_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = mets_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = mets_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (state_reg == mets_pkg::F_MUL)
        begin
            prod_re_reg  <= $signed({1'b0, col_reg}) * step_re;
            prod_im_reg  <= $signed({1'b0, row_reg}) * step_im;
            idx_prod_reg <= row_reg * eff_w;
        end
    end

    assign idx_sum = ISUM_W'(idx_prod_reg) + ISUM_W'(col_reg);

    always_comb
    begin
        point.c_re  = mets_pkg::sat_q(mets_pkg::PROD_W'(prod_re_reg)
                                      + mets_pkg::PROD_W'(view.left_re));
        point.c_im  = mets_pkg::sat_q(mets_pkg::PROD_W'(prod_im_reg)
                                      + mets_pkg::PROD_W'(view.top_im));
        point.index = idx_sum[mets_pkg::INDEX_W-1:0];
    end

    a_accept_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mets_pkg::F_DIV))
        else $error("front did not enter divide after accepting a pixel");

    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("front pushed into a full queue");

endmodule

@@ rtl/core/mets_queue.sv @@
// Short FIFO of mapped points between the front and back ends.
// Depends on mets_pkg for the entry type and depth.
module mets_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mets_pkg::point_t push_data,
    input  logic             pop,
    output mets_pkg::point_t head,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = mets_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mets_pkg::point_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

endmodule

@@ rtl/core/mets_back.sv @@
// Back end: escape-time iteration z = z*z + c on one point at a time, plus the
// result register. Depends on mets_pkg for types, constants and saturation.
module mets_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  mets_pkg::point_t              head,
    output logic                          pop,
    input  logic [mets_pkg::LIMIT_W-1:0]  iteration_limit,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [mets_pkg::LIMIT_W-1:0]  iteration_count,
    output logic [mets_pkg::INDEX_W-1:0]  pixel_index
);

    mets_pkg::back_state_t state_reg;
    mets_pkg::back_state_t state_next;

    logic signed [mets_pkg::Q_W-1:0]    c_re_reg;
    logic signed [mets_pkg::Q_W-1:0]    c_im_reg;
    logic signed [mets_pkg::Q_W-1:0]    z_re_reg;
    logic signed [mets_pkg::Q_W-1:0]    z_im_reg;
    logic signed [mets_pkg::Q_W-1:0]    z_re_next;
    logic signed [mets_pkg::Q_W-1:0]    z_im_next;
    logic [mets_pkg::INDEX_W-1:0]       index_reg;
    logic [mets_pkg::LIMIT_W-1:0]       n_reg;
    logic signed [mets_pkg::PROD_W-1:0] rr_prod_reg;
    logic signed [mets_pkg::PROD_W-1:0] ii_prod_reg;
    logic signed [mets_pkg::PROD_W-1:0] ri_prod_reg;
    logic signed [mets_pkg::PROD_W-1:0] rr;
    logic signed [mets_pkg::PROD_W-1:0] ii;
    logic signed [mets_pkg::PROD_W-1:0] ri2;
    logic                               escape;
    logic                               load_out;
    logic                               result_valid_reg;
    logic                               result_valid_next;
    logic [mets_pkg::LIMIT_W-1:0]       count_out_reg;
    logic [mets_pkg::INDEX_W-1:0]       index_out_reg;

    // arithmetic shift floors; 2*re*im is one bit less of shift
    always_comb
    begin
        rr        = rr_prod_reg >>> mets_pkg::FRAC_BITS;
        ii        = ii_prod_reg >>> mets_pkg::FRAC_BITS;
        ri2       = ri_prod_reg >>> (mets_pkg::FRAC_BITS - 1);
        escape    = (rr + ii) > mets_pkg::FOUR_Q;
        z_re_next = mets_pkg::sat_q(mets_pkg::PROD_W'(c_re_reg) + (rr - ii));
        z_im_next = mets_pkg::sat_q(mets_pkg::PROD_W'(c_im_reg) + ri2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mets_pkg::B_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            mets_pkg::B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = mets_pkg::B_MUL;
                end
            end
            mets_pkg::B_MUL:
            begin
                // limit test comes before the escape test
                if (n_reg == iteration_limit)
                    state_next = mets_pkg::B_DONE;
                else
                    state_next = mets_pkg::B_UPD;
            end
            mets_pkg::B_UPD:
            begin
                if (escape)
                    state_next = mets_pkg::B_DONE;
                else
                    state_next = mets_pkg::B_MUL;
            end
            mets_pkg::B_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = mets_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mets_pkg::B_IDLE;
            end
        endcase

        if (load_out)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            c_re_reg  <= head.c_re;
            c_im_reg  <= head.c_im;
            z_re_reg  <= head.c_re;
            z_im_reg  <= head.c_im;
            index_reg <= head.index;
            n_reg     <= '0;
        end
        else if (state_reg == mets_pkg::B_UPD && !escape)
        begin
            z_re_reg <= z_re_next;
            z_im_reg <= z_im_next;
            n_reg    <= n_reg + 1'b1;
        end

        if (state_reg == mets_pkg::B_MUL)
        begin
            rr_prod_reg <= z_re_reg * z_re_reg;
            ii_prod_reg <= z_im_reg * z_im_reg;
            ri_prod_reg <= z_re_reg * z_im_reg;
        end

        if (load_out)
        begin
            count_out_reg <= n_reg;
            index_out_reg <= index_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign iteration_count = count_out_reg;
    assign pixel_index     = index_out_reg;

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == mets_pkg::B_DONE))
        else $error("result raised outside the done state");

    a_pop_starts_iteration: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == mets_pkg::B_MUL))
        else $error("back end did not start iterating after pop");

endmodule

@@ rtl/core/mandelbrot_escape_time_pixel_top.sv @@
// Top level of the Mandelbrot escape-time pixel engine: configuration registers,
// front end, point queue and iteration back end. Depends on mets_pkg and all mets_* modules.
//
// Each request names a pixel by column and row; the engine maps it into the view
// window in signed Q4.28, iterates z = z*z + c from z = c until |z|^2 exceeds 4 or
// iteration_limit updates are done, and returns the update count with the linear
// index row*width+col. Each back-end update takes state B_MUL for the three 32x32
// products, then B_UPD for the escape test and saturating update. The front end takes
// a new pixel only after it has pushed the last one, and its bit-serial 32-step divider
// for the pixel steps sets its pace; a two-entry queue lets it map the next pixels while
// the back end iterates, so the slower of the two sets the pace. The user must write
// registers only while the engine has no pixel in flight; the block itself does not
// enforce this.
module mandelbrot_escape_time_pixel_top #(
    parameter int MAX_DIM = mets_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mets_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mets_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [mets_pkg::COORD_W-1:0]      pixel_col,
    input  logic [mets_pkg::COORD_W-1:0]      pixel_row,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [mets_pkg::LIMIT_W-1:0]      iteration_count,
    output logic [mets_pkg::INDEX_W-1:0]      pixel_index
);

    mets_pkg::view_t              view_reg;
    logic [mets_pkg::LIMIT_W-1:0] limit_reg;
    mets_pkg::point_t             push_point;
    mets_pkg::point_t             head_point;
    logic                         push;
    logic                         pop;
    logic                         queue_full;
    logic                         queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg.left_re   <= mets_pkg::RST_VIEW_LEFT_RE;
            view_reg.top_im    <= mets_pkg::RST_VIEW_TOP_IM;
            view_reg.right_re  <= mets_pkg::RST_VIEW_RIGHT_RE;
            view_reg.bottom_im <= mets_pkg::RST_VIEW_BOTTOM_IM;
            view_reg.width     <= mets_pkg::RST_IMAGE_WIDTH;
            view_reg.height    <= mets_pkg::RST_IMAGE_HEIGHT;
            limit_reg          <= mets_pkg::RST_ITER_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mets_pkg::REG_VIEW_LEFT_RE:    view_reg.left_re   <= cfg_data;
                mets_pkg::REG_VIEW_TOP_IM:     view_reg.top_im    <= cfg_data;
                mets_pkg::REG_VIEW_RIGHT_RE:   view_reg.right_re  <= cfg_data;
                mets_pkg::REG_VIEW_BOTTOM_IM:  view_reg.bottom_im <= cfg_data;
                mets_pkg::REG_IMAGE_WIDTH:
                    view_reg.width  <= cfg_data[mets_pkg::DIM_CFG_W-1:0];
                mets_pkg::REG_IMAGE_HEIGHT:
                    view_reg.height <= cfg_data[mets_pkg::DIM_CFG_W-1:0];
                mets_pkg::REG_ITERATION_LIMIT:
                    limit_reg       <= cfg_data[mets_pkg::LIMIT_W-1:0];
                default:
                begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    mets_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .view        (view_reg),
        .queue_full  (queue_full),
        .push        (push),
        .point       (push_point)
    );

    mets_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_point),
        .pop       (pop),
        .head      (head_point),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    mets_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .head            (head_point),
        .pop             (pop),
        .iteration_limit (limit_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .iteration_count (iteration_count),
        .pixel_index     (pixel_index)
    );

endmodule
